@@ rtl/lphm_pkg.sv @@
// types and codes shared by the hash map controller, datapath and top level
// no dependencies

package lphm_pkg;

	// request codes
	localparam logic [1:0] FN_INSERT = 2'd0;
	localparam logic [1:0] FN_REMOVE = 2'd1;
	localparam logic [1:0] FN_GET    = 2'd2;
	localparam logic [1:0] FN_NOP    = 2'd3;

	// slot state codes, code three reads like a tombstone
	localparam logic [1:0] ST_EMPTY = 2'd0;
	localparam logic [1:0] ST_LIVE  = 2'd1;
	localparam logic [1:0] ST_TOMB  = 2'd2;

	typedef struct packed {
		logic [1:0]  func;
		logic [63:0] key;
		logic [31:0] key_hash;
		logic [31:0] value_in;
	} req_t;

	typedef struct packed {
		logic        found;
		logic [31:0] value_out;
		logic        status;
		logic [5:0]  entry_count;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic clear;
		logic load;
		logic mul;
		logic scale;
		logic start;
		logic probe;
		logic finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic req_nop;
		logic probe_done;
		logic out_busy;
	} sts_t;

endpackage

@@ rtl/linear_probe_hash_map_unit.sv @@
// top level of the linear probing hash map: controller plus datapath
// depends on lphm_pkg, lphm_ctrl, lphm_dp
//
//   channel | payload          | handshake
//   --------+------------------+----------------------
//   req     | func, key, hash, | req_valid / req_stall
//           | value_in         |
//   rsp     | found, value_out,| rsp_valid / rsp_stall
//           | status, count    |
//
// one request at a time: transfer, then reduction of the hash to a start slot
// (multiply, multiply, compare-subtract), then one cycle per slot probed
// (registered memory read, next slot read ahead), then the table update and
// the result load; from 1 to SLOTS slots are probed
// an unused request code skips the reduction and the probe
// after reset a clearing pass empties the slot states, req stalled
// a stalled result waits in its register; the next request is taken meanwhile
// and holds before its update until the result register frees

module linear_probe_hash_map_unit #(
	parameter int SLOTS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  lphm_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output lphm_pkg::rsp_t rsp
);
	import lphm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	lphm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	lphm_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

@@ rtl/lphm_dp.sv @@
// hash map datapath: slot memories, start slot reduction, probe evaluation, result register
// depends on lphm_pkg

module lphm_dp #(
	parameter int SLOTS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  lphm_pkg::cmd_t cmd,
	output lphm_pkg::sts_t sts,
	input  lphm_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output lphm_pkg::rsp_t rsp
);
	import lphm_pkg::*;

	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);
	localparam logic [63:0] RECIP_W = 64'h1_0000_0000 / 64'(SLOTS);
	localparam logic [31:0] RECIP = RECIP_W[31:0];
	localparam logic [32:0] DIV = 33'(SLOTS);
	localparam logic [CW-1:0] FULL = CW'(SLOTS);

	logic [1:0]  state_mem [SLOTS];
	logic [63:0] key_mem [SLOTS];
	logic [31:0] val_mem [SLOTS];

	req_t          req_q;
	logic [31:0]   prod_s1;
	logic [31:0]   scaled_s2;
	logic [1:0]    st_rd_q;
	logic [63:0]   key_rd_q;
	logic [31:0]   val_rd_q;
	logic [IW-1:0] cur_q;
	logic [IW-1:0] cnt_q;
	logic          tomb_seen_q;
	logic [IW-1:0] tomb_q;
	logic          found_q;
	logic          ok_q;
	logic [IW-1:0] target_q;
	logic [31:0]   vout_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] clr_q;
	rsp_t          rsp_q;
	logic          rsp_valid_q;

	logic [63:0]   prod;
	logic [48:0]   scaled;
	logic [31:0]   rem;
	logic [IW-1:0] start_idx;
	logic [IW-1:0] nxt_idx;
	logic [IW-1:0] rd_addr;
	logic          is_empty;
	logic          is_live;
	logic          is_tomb;
	logic          hit;
	logic          done;
	logic          ins_ok;
	logic [IW-1:0] ins_idx;
	logic          is_ins;
	logic          is_rem;
	logic          is_get;
	logic          add_new;
	logic          st_we;
	logic [IW-1:0] wr_addr;
	logic [1:0]    st_wd;
	logic          key_we;
	logic          val_we;
	logic [CW-1:0] count_nxt;
	rsp_t          rsp_nxt;

	// start slot = hash mod SLOTS by reciprocal, estimate is low by at most one
	assign prod   = 64'(req_q.key_hash) * 64'(RECIP);
	assign scaled = 49'(prod_s1) * 49'(SLOTS);
	assign rem    = req_q.key_hash - scaled_s2;
	assign start_idx = (33'(rem) >= DIV) ? IW'(rem - DIV[31:0]) : IW'(rem);

	assign nxt_idx = (cur_q == LAST) ? '0 : cur_q + IW'(1);
	assign rd_addr = cmd.start ? start_idx : nxt_idx;

	// probe evaluation of the slot whose data sits in the read registers
	assign is_empty = (st_rd_q == ST_EMPTY);
	assign is_live  = (st_rd_q == ST_LIVE);
	assign is_tomb  = !is_empty && !is_live;
	assign hit      = is_live && (key_rd_q == req_q.key);
	assign done     = is_empty || hit || (cnt_q == LAST);
	assign ins_ok   = is_empty || tomb_seen_q || is_tomb;
	assign ins_idx  = (!is_empty && tomb_seen_q) ? tomb_q : cur_q;

	assign is_ins  = (req_q.func == FN_INSERT);
	assign is_rem  = (req_q.func == FN_REMOVE);
	assign is_get  = (req_q.func == FN_GET);
	assign add_new = is_ins && !found_q && ok_q;

	assign st_we   = cmd.clear || (cmd.finish && (add_new || (is_rem && found_q)));
	assign wr_addr = cmd.clear ? clr_q : target_q;
	assign st_wd   = cmd.clear ? ST_EMPTY : (is_ins ? ST_LIVE : ST_TOMB);
	assign key_we  = cmd.finish && add_new;
	assign val_we  = cmd.finish && is_ins && (found_q || ok_q);

	always_comb begin
		count_nxt = count_q;
		if (add_new) begin
			count_nxt = count_q + CW'(1);
		end else if (is_rem && found_q && (count_q != '0)) begin
			count_nxt = count_q - CW'(1);
		end
		rsp_nxt.found       = found_q;
		rsp_nxt.value_out   = (is_get && found_q) ? vout_q : 32'd0;
		rsp_nxt.status      = is_ins && !found_q && !ok_q;
		rsp_nxt.entry_count = 6'(count_nxt);
	end

	always_ff @(posedge clk) begin
		st_rd_q  <= state_mem[rd_addr];
		key_rd_q <= key_mem[rd_addr];
		val_rd_q <= val_mem[rd_addr];
		if (st_we) begin
			state_mem[wr_addr] <= st_wd;
		end
		if (key_we) begin
			key_mem[target_q] <= req_q.key;
		end
		if (val_we) begin
			val_mem[target_q] <= req_q.value_in;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q   <= req;
			found_q <= 1'b0;
			ok_q    <= 1'b0;
		end
		if (cmd.mul) begin
			prod_s1 <= prod[63:32];
		end
		if (cmd.scale) begin
			scaled_s2 <= scaled[31:0];
		end
		if (cmd.probe) begin
			if (is_tomb && !tomb_seen_q) begin
				tomb_q <= cur_q;
			end
			if (done) begin
				found_q  <= hit;
				ok_q     <= ins_ok;
				target_q <= hit ? cur_q : ins_idx;
				vout_q   <= val_rd_q;
			end
		end
		if (cmd.finish) begin
			rsp_q <= rsp_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= '0;
			cnt_q       <= '0;
			tomb_seen_q <= 1'b0;
			count_q     <= '0;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				clr_q <= clr_q + IW'(1);
			end
			if (cmd.start) begin
				cur_q       <= start_idx;
				cnt_q       <= '0;
				tomb_seen_q <= 1'b0;
			end else if (cmd.probe) begin
				cur_q <= nxt_idx;
				cnt_q <= cnt_q + IW'(1);
				if (is_tomb) begin
					tomb_seen_q <= 1'b1;
				end
			end
			if (cmd.finish) begin
				count_q     <= count_nxt;
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign sts.clr_last   = (clr_q == LAST);
	assign sts.req_nop    = (req.func == FN_NOP);
	assign sts.probe_done = done;
	assign sts.out_busy   = rsp_valid_q && rsp_stall;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !(rsp_valid_q && rsp_stall))
		else $error("result register overwritten while stalled");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL)
		else $error("live entry count above table size");

	a_full_means_all_live: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.status) |-> (count_q == FULL))
		else $error("table full reported with free slots");

	a_finish_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> rsp_valid_q)
		else $error("finished operation left no result");

endmodule

@@ rtl/lphm_ctrl.sv @@
// hash map controller: clearing pass, start slot reduction, probe loop, result hand-off
// depends on lphm_pkg

module lphm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	output lphm_pkg::cmd_t cmd,
	input  lphm_pkg::sts_t sts
);
	import lphm_pkg::*;

	typedef enum logic [6:0] {
		S_CLEAR  = 7'b0000001,
		S_IDLE   = 7'b0000010,
		S_MUL    = 7'b0000100,
		S_SCALE  = 7'b0001000,
		S_REDUCE = 7'b0010000,
		S_PROBE  = 7'b0100000,
		S_FINISH = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clr_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.load  = 1'b1;
					state_nxt = sts.req_nop ? S_FINISH : S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = S_SCALE;
			end
			S_SCALE: begin
				cmd.scale = 1'b1;
				state_nxt = S_REDUCE;
			end
			S_REDUCE: begin
				cmd.start = 1'b1;
				state_nxt = S_PROBE;
			end
			S_PROBE: begin
				cmd.probe = 1'b1;
				if (sts.probe_done) begin
					state_nxt = S_FINISH;
				end
			end
			S_FINISH: begin
				if (!sts.out_busy) begin
					cmd.finish = 1'b1;
					state_nxt  = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign req_stall = (state_q != S_IDLE);

endmodule
